// File: rtl/request_frame_check_and_reply_macros.svh
// Assertion macros for the request frame checker. Define ASSERT_OFF to drop them.
`ifndef REQUEST_FRAME_CHECK_AND_REPLY_MACROS_SVH
`define REQUEST_FRAME_CHECK_AND_REPLY_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge of i_clk outside reset.
`define RFCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset cycles included.
`define RFCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define RFCR_ASSERT(lbl, prop, msg)
`define RFCR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/rfcr_pkg.sv
package rfcr_pkg;

    localparam int RFCR_MEM_DEPTH = 128;
    localparam int RFCR_MAX_WORDS = 11;

    // Byte positions inside a request frame. The first six reply bytes
    // follow the same layout.
    localparam logic [3:0] POS_START   = 4'd0;
    localparam logic [3:0] POS_ADDR_HI = 4'd1;
    localparam logic [3:0] POS_ADDR_LO = 4'd2;
    localparam logic [3:0] POS_FUNC    = 4'd3;
    localparam logic [3:0] POS_SA_HI   = 4'd4;
    localparam logic [3:0] POS_SA_LO   = 4'd5;
    localparam logic [3:0] POS_COUNT   = 4'd6;
    localparam logic [3:0] POS_PAD0    = 4'd7;
    localparam logic [3:0] POS_PAD1    = 4'd8;
    localparam logic [3:0] POS_END     = 4'd9;
    localparam logic [3:0] POS_SUM_HI  = 4'd10;
    localparam logic [3:0] POS_SUM_LO  = 4'd11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OWN_ADDR     = 2'd0;
    localparam logic [1:0] CFG_START_MARKER = 2'd1;
    localparam logic [1:0] CFG_END_MARKER   = 2'd2;
    localparam logic [1:0] CFG_READ_FUNC    = 2'd3;

    localparam logic [15:0] RST_OWN_ADDR     = 16'd1;
    localparam logic [7:0]  RST_START_MARKER = 8'd2;
    localparam logic [7:0]  RST_END_MARKER   = 8'd3;
    localparam logic [7:0]  RST_READ_FUNC    = 8'd0;

    // A completed request frame, handed from the receiver to the replier.
    typedef struct packed {
        logic        go;
        logic        ok;
        logic [7:0]  func;
        logic [15:0] start;
        logic [7:0]  count;
    } t_frame;

endpackage

// File: rtl/request_frame_check_and_reply.sv
// A rejected frame goes from S_IDLE to S_REJ, which puts its single result byte into the
// output register once it is free. A valid frame first takes 3 address wrap steps in S_MOD,
// then starts its reply in S_HDR. Request bytes and word writes are taken one per cycle
// while tready is high; a reply has six header bytes, a memory read plus two bytes per data
// word, and three closing bytes. Reset (synchronous, active low) clears control and then
// zeroes the data memory, one entry per cycle, while no input transaction is taken.
module request_frame_check_and_reply #(
    parameter int MEM_DEPTH = rfcr_pkg::RFCR_MEM_DEPTH,
    parameter int MAX_WORDS = rfcr_pkg::RFCR_MAX_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, lowest bit first: frame_byte[7:0], frame_start[8], word_index[15:9],
    // word_value[31:16].
    input  logic [31:0] i_s_tdata,
    // tuser: kind (0 request frame byte, 1 data memory word write).
    input  logic        i_s_tuser,
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: reply_byte[7:0].
    output logic [7:0]  o_m_tdata,
    // tuser: frame_ok.
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "request_frame_check_and_reply_macros.svh"

    localparam int AW = $clog2(MEM_DEPTH);

    // Configuration registers. The user must change them only between requests (the
    // block does not enforce it), so the receiver and the replier read them directly.
    logic [15:0] r_own_addr;
    logic [7:0]  r_start_marker;
    logic [7:0]  r_end_marker;
    logic [7:0]  r_read_func;

    logic              w_in_xfer;
    logic              w_byte_valid;
    logic              w_word_xfer;
    logic [16:0]       w_idx_ext;
    logic              w_wr_en;
    logic              w_clearing;
    logic              w_tx_idle;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [15:0]       w_rd_data;
    rfcr_pkg::t_frame  w_frame;
    logic              w_reject_out;
    logic              w_reject_form;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr     <= rfcr_pkg::RST_OWN_ADDR;
            r_start_marker <= rfcr_pkg::RST_START_MARKER;
            r_end_marker   <= rfcr_pkg::RST_END_MARKER;
            r_read_func    <= rfcr_pkg::RST_READ_FUNC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfcr_pkg::CFG_OWN_ADDR:     r_own_addr     <= i_cfg_data;
                rfcr_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data[7:0];
                rfcr_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_data[7:0];
                rfcr_pkg::CFG_READ_FUNC:    r_read_func    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The block works on one request at a time: while a reply is being
    // built, or while the memory is being cleared after reset, no input
    // transaction is taken. The last reply byte may still wait in the
    // output register while the next request streams in.
    assign o_s_tready   = w_tx_idle && !w_clearing;
    assign w_in_xfer    = i_s_tvalid && o_s_tready;
    assign w_byte_valid = w_in_xfer && !i_s_tuser;
    assign w_word_xfer  = w_in_xfer && i_s_tuser;

    // Word writes to an index beyond the memory are dropped.
    assign w_idx_ext = 17'(i_s_tdata[15:9]);
    assign w_wr_en   = w_word_xfer && (w_idx_ext < 17'(MEM_DEPTH));

    rfcr_rx u_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (w_byte_valid),
        .i_byte         (i_s_tdata[7:0]),
        .i_frame_start  (i_s_tdata[8]),
        .i_own_addr     (r_own_addr),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_frame        (w_frame)
    );

    rfcr_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_idx_ext[AW-1:0]),
        .i_wr_data  (i_s_tdata[31:16]),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    rfcr_tx #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAX_WORDS (MAX_WORDS)
    ) u_tx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (w_frame),
        .i_own_addr     (r_own_addr),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .i_read_func    (r_read_func),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_idle         (w_tx_idle),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_byte         (o_m_tdata),
        .o_ok           (o_m_tuser),
        .o_last         (o_m_tlast)
    );

    // A rejection on the output and the shape it must have.
    assign w_reject_out  = o_m_tvalid && !o_m_tuser;
    assign w_reject_form = o_m_tlast && (o_m_tdata == 8'h00);

    // Input must stay closed while the memory is still being zeroed.
    `RFCR_ASSERT(a_clear_blocks_input, w_clearing |-> !o_s_tready, "input taken during clear")

    // A completed frame must close the input on the next cycle.
    `RFCR_ASSERT(a_frame_closes_input, w_frame.go |=> !o_s_tready, "input open after frame")

    // A rejection is a single zero byte that ends its request.
    `RFCR_ASSERT(a_reject_form, w_reject_out |-> w_reject_form, "bad rejection result")

    // Reset leaves no result pending.
    `RFCR_ASSERT_ALWAYS(a_reset_empties_output, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

// File: rtl/rfcr_rx.sv
module rfcr_rx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_byte_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_frame_start,
    input  logic [15:0]         i_own_addr,
    input  logic [7:0]          i_start_marker,
    input  logic [7:0]          i_end_marker,
    output rfcr_pkg::t_frame    o_frame
);

    logic [3:0]  r_pos;
    logic [3:0]  w_pos;
    logic [15:0] r_sum;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [7:0]  r_b9;
    logic [7:0]  r_b10;
    logic [7:0]  r_func;
    logic [7:0]  r_sa_hi;
    logic [7:0]  r_sa_lo;
    logic [7:0]  r_count;

    // A start flag always puts the byte at the head of a new frame.
    assign w_pos = i_frame_start ? rfcr_pkg::POS_START : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= rfcr_pkg::POS_START;
        end else if (i_byte_valid) begin
            r_pos <= (w_pos == rfcr_pkg::POS_SUM_LO) ? rfcr_pkg::POS_START : w_pos + 4'd1;
        end
    end

    // Header fields are kept raw; the comparisons against the configuration
    // happen only once the last byte is in.
    always_ff @(posedge i_clk) begin
        if (i_byte_valid) begin
            unique case (w_pos) inside
                rfcr_pkg::POS_START: begin
                    r_b0  <= i_byte;
                    r_sum <= 16'(i_byte);
                end
                rfcr_pkg::POS_ADDR_HI: begin
                    r_b1  <= i_byte;
                    r_sum <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_ADDR_LO: begin
                    r_b2  <= i_byte;
                    r_sum <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_FUNC: begin
                    r_func <= i_byte;
                    r_sum  <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_SA_HI: begin
                    r_sa_hi <= i_byte;
                    r_sum   <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_SA_LO: begin
                    r_sa_lo <= i_byte;
                    r_sum   <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_COUNT: begin
                    r_count <= i_byte;
                    r_sum   <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_PAD0, rfcr_pkg::POS_PAD1: begin
                    r_sum <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_END: begin
                    r_b9  <= i_byte;
                    r_sum <= r_sum + 16'(i_byte);
                end
                rfcr_pkg::POS_SUM_HI: begin
                    r_b10 <= i_byte;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_frame.go    = i_byte_valid && (w_pos == rfcr_pkg::POS_SUM_LO);
        o_frame.ok    = (r_b0 == i_start_marker) && ({r_b1, r_b2} == i_own_addr) &&
                        (r_b9 == i_end_marker) && (r_b10 == r_sum[15:8]) &&
                        (i_byte == r_sum[7:0]);
        o_frame.func  = r_func;
        o_frame.start = {r_sa_hi, r_sa_lo};
        o_frame.count = r_count;
    end

endmodule

// File: rtl/rfcr_dmem.sv
module rfcr_dmem #(
    parameter int MEM_DEPTH = rfcr_pkg::RFCR_MEM_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]                  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_rd_addr,
    output logic [15:0]                  o_rd_data,
    output logic                         o_clearing
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [15:0]   r_mem [MEM_DEPTH];
    logic [15:0]   r_rd_data;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [15:0]   w_data;

    // After reset every entry is written with zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign w_we   = r_clr || i_wr_en;
    assign w_addr = r_clr ? r_clr_addr : i_wr_addr;
    assign w_data = r_clr ? 16'h0000 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr;

endmodule

// File: rtl/rfcr_tx.sv
module rfcr_tx #(
    parameter int MEM_DEPTH = rfcr_pkg::RFCR_MEM_DEPTH,
    parameter int MAX_WORDS = rfcr_pkg::RFCR_MAX_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfcr_pkg::t_frame             i_frame,
    input  logic [15:0]                  i_own_addr,
    input  logic [7:0]                   i_start_marker,
    input  logic [7:0]                   i_end_marker,
    input  logic [7:0]                   i_read_func,
    output logic                         o_rd_en,
    output logic [$clog2(MEM_DEPTH)-1:0] o_rd_addr,
    input  logic [15:0]                  i_rd_data,
    output logic                         o_idle,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_byte,
    output logic                         o_ok,
    output logic                         o_last
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int MOD_W = 17;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    // Scaled reciprocal of the memory depth. The quotient estimate taken with it
    // is at most one below the true quotient for any 16-bit start address.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / MEM_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REJ,
        S_MOD,
        S_HDR,
        S_RD,
        S_HI,
        S_LO,
        S_END,
        S_SUMH,
        S_SUML
    } t_state;

    t_state           r_state;
    logic [7:0]       r_func;
    logic [15:0]      r_sa;
    logic [1:0]       r_mod_step;
    logic [15:0]      r_quo;
    logic [15:0]      r_rem;
    logic [AW-1:0]    r_addr;
    logic [CNT_W-1:0] r_left;
    logic [3:0]       r_hidx;
    logic [15:0]      r_sum;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_ok;
    logic             r_out_last;

    logic             w_can_load;
    logic             w_load;
    logic             w_is_read;
    logic [15:0]      w_word;
    logic [7:0]       w_hdr_byte;
    logic [47:0]      w_quo_prod;
    logic [31:0]      w_quo_mul;
    logic [MOD_W-1:0] w_rem_fix;
    logic [AW-1:0]    w_addr_nx;
    logic [CNT_W-1:0] w_count;

    assign w_can_load = !r_out_valid || i_ready;
    // States that put a byte into the output register when it is free.
    assign w_load     = w_can_load && !(r_state inside {S_IDLE, S_MOD, S_RD});
    assign w_is_read  = (r_func == i_read_func);
    assign w_word     = w_is_read ? i_rd_data : 16'h0000;

    // Start address modulo the memory depth in three steps: quotient estimate,
    // remainder estimate, then one correcting subtraction.
    assign w_quo_prod = 48'(r_sa) * 48'(RECIP);
    assign w_quo_mul  = 32'(r_quo) * 32'(MEM_DEPTH);
    assign w_rem_fix  = (MOD_W'(r_rem) >= MOD_W'(MEM_DEPTH)) ?
                        MOD_W'(r_rem) - MOD_W'(MEM_DEPTH) : MOD_W'(r_rem);

    assign w_addr_nx = (r_addr == AW'(MEM_DEPTH - 1)) ? '0 : r_addr + AW'(1);

    assign w_count = (i_frame.count > 8'(MAX_WORDS)) ? CNT_W'(MAX_WORDS)
                                                     : i_frame.count[CNT_W-1:0];

    always_comb begin
        unique case (r_hidx)
            rfcr_pkg::POS_START:   w_hdr_byte = i_start_marker;
            rfcr_pkg::POS_ADDR_HI: w_hdr_byte = i_own_addr[15:8];
            rfcr_pkg::POS_ADDR_LO: w_hdr_byte = i_own_addr[7:0];
            rfcr_pkg::POS_FUNC:    w_hdr_byte = r_func;
            rfcr_pkg::POS_SA_HI:   w_hdr_byte = r_sa[15:8];
            rfcr_pkg::POS_SA_LO:   w_hdr_byte = r_sa[7:0];
            default:               w_hdr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_frame.go) begin
                        r_func     <= i_frame.func;
                        r_sa       <= i_frame.start;
                        r_mod_step <= '0;
                        r_left     <= w_count;
                        r_hidx     <= rfcr_pkg::POS_START;
                        r_sum      <= '0;
                        r_state    <= i_frame.ok ? S_MOD : S_REJ;
                    end
                end
                S_REJ: begin
                    if (w_can_load) begin
                        r_out_byte  <= 8'h00;
                        r_out_ok    <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_MOD: begin
                    r_mod_step <= r_mod_step + 2'd1;
                    if (r_mod_step == 2'd0) begin
                        r_quo <= w_quo_prod[47:32];
                    end else if (r_mod_step == 2'd1) begin
                        r_rem <= r_sa - w_quo_mul[15:0];
                    end else begin
                        r_addr  <= w_rem_fix[AW-1:0];
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    if (w_can_load) begin
                        r_out_byte  <= w_hdr_byte;
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_sum       <= r_sum + 16'(w_hdr_byte);
                        r_hidx      <= r_hidx + 4'd1;
                        if (r_hidx == rfcr_pkg::POS_SA_LO) begin
                            r_state <= (r_left == '0) ? S_END : S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_HI;
                end
                S_HI: begin
                    if (w_can_load) begin
                        r_out_byte  <= w_word[15:8];
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_sum       <= r_sum + 16'(w_word[15:8]);
                        r_state     <= S_LO;
                    end
                end
                S_LO: begin
                    if (w_can_load) begin
                        r_out_byte  <= w_word[7:0];
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_sum       <= r_sum + 16'(w_word[7:0]);
                        r_addr      <= w_addr_nx;
                        r_left      <= r_left - CNT_W'(1);
                        r_state     <= (r_left == CNT_W'(1)) ? S_END : S_RD;
                    end
                end
                S_END: begin
                    if (w_can_load) begin
                        r_out_byte  <= i_end_marker;
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_sum       <= r_sum + 16'(i_end_marker);
                        r_state     <= S_SUMH;
                    end
                end
                S_SUMH: begin
                    if (w_can_load) begin
                        r_out_byte  <= r_sum[15:8];
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_state     <= S_SUML;
                    end
                end
                S_SUML: begin
                    if (w_can_load) begin
                        r_out_byte  <= r_sum[7:0];
                        r_out_ok    <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rd_en   = (r_state == S_RD);
    assign o_rd_addr = r_addr;
    assign o_idle    = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_byte    = r_out_byte;
    assign o_ok      = r_out_ok;
    assign o_last    = r_out_last;

endmodule

// File: verif/request_frame_check_and_reply_test.sv
// What one input transaction carries, sent on tuser.
typedef enum logic {
    ITEM_FRAME_BYTE = 1'b0,
    ITEM_WORD_WRITE = 1'b1
} t_item_kind;

// One reply transaction as it leaves the block.
typedef struct packed {
    logic [7:0] data;
    logic       ok;
    logic       is_last;
} t_reply_beat;

// Keeps its own copy of the registers, the request bytes and the data memory.
// Every accepted input is replayed here to queue the reply beats it causes.
class t_reply_tracker;
    localparam int FRAME_BYTES = 12;

    logic [15:0] own_addr;
    logic [7:0]  stx;
    logic [7:0]  etx;
    logic [7:0]  read_func;
    logic [7:0]  req [FRAME_BYTES];
    int unsigned pos;
    logic [15:0] mem [rfcr_pkg::RFCR_MEM_DEPTH];
    t_reply_beat pending [$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned frames_answered;
    int unsigned frames_rejected;
    int unsigned words_written;

    function new();
        own_addr  = rfcr_pkg::RST_OWN_ADDR;
        stx       = rfcr_pkg::RST_START_MARKER;
        etx       = rfcr_pkg::RST_END_MARKER;
        read_func = rfcr_pkg::RST_READ_FUNC;
        pos       = 0;
        foreach (req[i]) req[i] = 8'h00;
        foreach (mem[i]) mem[i] = 16'h0000;
        mismatches      = 0;
        beats_checked   = 0;
        frames_answered = 0;
        frames_rejected = 0;
        words_written   = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            rfcr_pkg::CFG_OWN_ADDR:     own_addr  = val;
            rfcr_pkg::CFG_START_MARKER: stx       = val[7:0];
            rfcr_pkg::CFG_END_MARKER:   etx       = val[7:0];
            rfcr_pkg::CFG_READ_FUNC:    read_func = val[7:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending_count();
        return pending.size();
    endfunction

    function void accept_input(input t_item_kind kind, input logic [31:0] data);
        logic [15:0] sum;
        logic [7:0]  beats [$];
        int unsigned count;
        int unsigned first_word;
        logic [15:0] word;
        t_reply_beat beat;

        if (kind == ITEM_WORD_WRITE) begin
            // The index field is seven bits, so every write lands in memory.
            mem[data[15:9]] = data[31:16];
            words_written++;
            return;
        end

        if (data[8]) pos = 0;
        if (pos >= FRAME_BYTES) pos = 0;
        req[pos] = data[7:0];
        pos++;
        if (pos < FRAME_BYTES) return;
        pos = 0;

        sum = 16'h0000;
        for (int i = 0; i < 10; i++) sum += req[i];
        if ({req[rfcr_pkg::POS_ADDR_HI], req[rfcr_pkg::POS_ADDR_LO]} != own_addr ||
            req[rfcr_pkg::POS_START] != stx || req[rfcr_pkg::POS_END] != etx ||
            req[rfcr_pkg::POS_SUM_HI] != sum[15:8] ||
            req[rfcr_pkg::POS_SUM_LO] != sum[7:0]) begin
            beat = '{data: 8'h00, ok: 1'b0, is_last: 1'b1};
            pending.push_back(beat);
            frames_rejected++;
            return;
        end

        count = req[rfcr_pkg::POS_COUNT];
        if (count > rfcr_pkg::RFCR_MAX_WORDS) count = rfcr_pkg::RFCR_MAX_WORDS;
        first_word = {req[rfcr_pkg::POS_SA_HI], req[rfcr_pkg::POS_SA_LO]};

        beats.push_back(stx);
        beats.push_back(own_addr[15:8]);
        beats.push_back(own_addr[7:0]);
        beats.push_back(req[rfcr_pkg::POS_FUNC]);
        beats.push_back(req[rfcr_pkg::POS_SA_HI]);
        beats.push_back(req[rfcr_pkg::POS_SA_LO]);
        for (int unsigned k = 0; k < count; k++) begin
            word = 16'h0000;
            if (req[rfcr_pkg::POS_FUNC] == read_func)
                word = mem[(first_word + k) % rfcr_pkg::RFCR_MEM_DEPTH];
            beats.push_back(word[15:8]);
            beats.push_back(word[7:0]);
        end
        beats.push_back(etx);
        sum = 16'h0000;
        foreach (beats[i]) sum += beats[i];
        beats.push_back(sum[15:8]);
        beats.push_back(sum[7:0]);

        foreach (beats[i]) begin
            beat = '{data: beats[i], ok: 1'b1, is_last: (i == beats.size() - 1)};
            pending.push_back(beat);
        end
        frames_answered++;
    endfunction

    function void check_reply(input logic [7:0] data, input logic ok, input logic is_last);
        t_reply_beat want;

        beats_checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected reply transaction data=%02h ok=%0b last=%0b",
                         data, ok, is_last);
            return;
        end
        want = pending.pop_front();
        if (want.data !== data || want.ok !== ok || want.is_last !== is_last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: reply mismatch expected data=%02h ok=%0b last=%0b, %s%02h %s%0b %s%0b",
                         want.data, want.ok, want.is_last,
                         "got data=", data, "ok=", ok, "last=", is_last);
        end
    endfunction
endclass

module request_frame_check_and_reply_test;

    // Generous ceiling on the whole run; a normal run needs a small fraction of it.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // A valid reply waits for the address steps of the replier, so this
    // many quiet cycles cover any work still in flight.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS_PER_PHASE = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // tdata, lowest bit first: frame_byte[7:0], frame_start[8], word_index[15:9],
    // word_value[31:16].
    logic [31:0] i_s_tdata;
    // tuser: kind.
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // tdata: reply_byte[7:0].
    logic [7:0]  o_m_tdata;
    // tuser: frame_ok.
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    t_reply_tracker tracker = new();

    int unsigned cycle_count;
    int unsigned items_sent;
    int          burst_left;
    int unsigned settings_used;

    // Receiver stall pattern: a mode is held for a random stretch of cycles.
    int unsigned stall_mode;
    int unsigned stall_mode_left;
    int unsigned ready_tick;

    request_frame_check_and_reply u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The cycle counter doubles as the watchdog for a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reply transactions still expected.",
                     cycle_count, tracker.pending_count());
            $display("request_frame_check_and_reply regression: fail");
            $finish;
        end
    end

    // The receiver switches between always ready, coin-flip ready, ready in a repeating
    // pattern and rarely ready, so that back pressure can land on any reply byte.
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (stall_mode_left == 0) begin
            stall_mode      <= $urandom_range(0, 3);
            stall_mode_left <= $urandom_range(20, 200);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= (ready_tick % 3 == 0);
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Every reply transaction is checked against the oldest expected beat. The
    // values read here are the ones that stood before this clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_reply(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // Unused fields of tdata are filled with random bits so that every bit of
    // the bus toggles regardless of the transaction kind.
    function automatic logic [31:0] pack_frame_byte(input logic [7:0] b, input logic first);
        return {16'($urandom), 7'($urandom), first, b};
    endfunction

    function automatic logic [31:0] pack_word_write(input logic [6:0] idx,
                                                    input logic [15:0] val);
        return {val, idx, 1'($urandom), 8'($urandom)};
    endfunction

    // Sends one input transaction. The sender works in bursts; when a burst is
    // used up it may drop tvalid for a random gap before starting the next one.
    task automatic push_item(input t_item_kind kind, input logic [31:0] data);
        int gap;

        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker.accept_input(kind, data);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_word_write(input logic [6:0] idx, input logic [15:0] val);
        push_item(ITEM_WORD_WRITE, pack_word_write(idx, val));
    endtask

    // Builds a request frame for the current settings and sends it. A corrupt
    // position of -1 keeps the frame well formed; any other position gets one
    // byte flipped, which always makes the frame fail its checks. Word writes may
    // be slipped in between the bytes.
    task automatic send_request(input logic [7:0] func, input logic [15:0] first_word,
                                input logic [7:0] count, input int corrupt_pos,
                                input logic mark_first, input int write_pct);
        logic [7:0]  frame [12];
        logic [15:0] sum;

        frame[rfcr_pkg::POS_START]   = tracker.stx;
        frame[rfcr_pkg::POS_ADDR_HI] = tracker.own_addr[15:8];
        frame[rfcr_pkg::POS_ADDR_LO] = tracker.own_addr[7:0];
        frame[rfcr_pkg::POS_FUNC]    = func;
        frame[rfcr_pkg::POS_SA_HI]   = first_word[15:8];
        frame[rfcr_pkg::POS_SA_LO]   = first_word[7:0];
        frame[rfcr_pkg::POS_COUNT]   = count;
        frame[rfcr_pkg::POS_PAD0]    = 8'($urandom);
        frame[rfcr_pkg::POS_PAD1]    = 8'($urandom);
        frame[rfcr_pkg::POS_END]     = tracker.etx;
        sum = 16'h0000;
        for (int i = 0; i < 10; i++) sum += frame[i];
        frame[rfcr_pkg::POS_SUM_HI] = sum[15:8];
        frame[rfcr_pkg::POS_SUM_LO] = sum[7:0];
        if (corrupt_pos >= 0)
            frame[corrupt_pos] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < 12; i++) begin
            if ($urandom_range(0, 99) < write_pct)
                push_word_write(7'($urandom), 16'($urandom));
            push_item(ITEM_FRAME_BYTE, pack_frame_byte(frame[i], (i == 0) && mark_first));
        end
    endtask

    // Stray request bytes: a broken or truncated frame.
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            push_item(ITEM_FRAME_BYTE, pack_frame_byte(8'($urandom), 1'($urandom)));
    endtask

    // Holds the sender until every expected reply has come, then lets the block
    // go quiet. Registers are only written after this.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive cycles.
    task automatic configure(input logic [15:0] addr, input logic [7:0] start_mark,
                             input logic [7:0] end_mark, input logic [7:0] rd_func);
        logic [15:0] vals [4];

        vals[rfcr_pkg::CFG_OWN_ADDR]     = addr;
        vals[rfcr_pkg::CFG_START_MARKER] = {8'h00, start_mark};
        vals[rfcr_pkg::CFG_END_MARKER]   = {8'h00, end_mark};
        vals[rfcr_pkg::CFG_READ_FUNC]    = {8'h00, rd_func};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            tracker.set_reg(2'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed requests with random content, spiced with corrupted
    // frames, word writes and stray bytes. A phase goes on until the byte
    // position is back at zero, so no partial frame is left before the next
    // register change.
    task automatic run_random(input int target);
        int unsigned first_item;
        int          pick;
        logic [7:0]  func;
        logic [15:0] first_word;
        logic [7:0]  count;
        int          corrupt_pos;

        first_item = items_sent;
        while (items_sent - first_item < target || tracker.pos != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                func        = ($urandom_range(0, 1) == 1) ? tracker.read_func : 8'($urandom);
                first_word  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 127));
                count       = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(12, 255))
                                                          : 8'($urandom_range(0, 11));
                corrupt_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : -1;
                send_request(func, first_word, count, corrupt_pos,
                             ($urandom_range(0, 9) != 0), 10);
            end else if (pick < 85) begin
                push_word_write(7'($urandom), 16'($urandom));
            end else begin
                send_noise($urandom_range(1, 11));
            end
        end
        drain();
    endtask

    initial begin
        cycle_count     = 0;
        items_sent      = 0;
        burst_left      = 0;
        settings_used   = 1;
        stall_mode      = 0;
        stall_mode_left = 0;
        ready_tick      = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 32'h0000_0000;
        i_s_tuser  <= ITEM_FRAME_BYTE;
        i_m_tready <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= rfcr_pkg::CFG_OWN_ADDR;
        i_cfg_data <= 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings. The memory clear after reset
        // holds tready low, so the first transaction simply waits for it.
        push_word_write(7'd127, 16'h8001);
        push_word_write(7'd0,   16'hFFFF);
        // A read that wraps past the top of memory, then a read with a start
        // address of all ones and a count far above the clamp.
        send_request(tracker.read_func, 16'h007F, 8'd2,   -1, 1'b1, 0);
        send_request(tracker.read_func, 16'hFFFF, 8'd255, -1, 1'b1, 0);
        // Any other function returns the same length of reply with zero data.
        send_request(8'hFF, 16'h0000, 8'd11, -1, 1'b1, 0);
        // A frame whose low sum byte is wrong is rejected.
        send_request(tracker.read_func, 16'h0000, 8'd2, rfcr_pkg::POS_SUM_LO, 1'b1, 0);
        // A truncated frame cut short by a fresh start byte.
        send_noise(3);
        send_request(tracker.read_func, 16'h0001, 8'd3, -1, 1'b1, 0);
        drain();
        run_random(RANDOM_ITEMS_PER_PHASE);

        configure(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        run_random(RANDOM_ITEMS_PER_PHASE);

        configure(16'h0000, 8'h00, 8'hFF, 8'h00);
        run_random(RANDOM_ITEMS_PER_PHASE);

        configure(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(RANDOM_ITEMS_PER_PHASE);

        $display("Sent %0d input transactions under %0d register settings: %0d requests %s",
                 items_sent, settings_used, tracker.frames_answered + tracker.frames_rejected,
                 "checked");
        $display("%0d answered, %0d rejected, %0d word writes, %0d reply transactions, %0d bad.",
                 tracker.frames_answered, tracker.frames_rejected, tracker.words_written,
                 tracker.beats_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
            $display("request_frame_check_and_reply regression: pass");
        end else begin
            $display("request_frame_check_and_reply regression: fail");
        end
        $finish;
    end
endmodule
